FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros used by the checker file uasp_checker.sv
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define UASP_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define UASP_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define UASP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/uasp_pkg.sv
// ----------------------------------------------------------------------------
// uasp_pkg
// types, codes and constants of the archive stream parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uasp_pkg;

  // field counter width: holds header or size field position, or content offset
  localparam int FCNT_W = 31;

  localparam logic [31:0] VERSION_RST = 32'd10001;

  localparam logic [FCNT_W-1:0] FC_MAGIC_LEN = FCNT_W'(4);
  localparam logic [FCNT_W-1:0] FC_VER_LAST  = FCNT_W'(7);
  localparam logic [FCNT_W-1:0] FC_CNT_LAST  = FCNT_W'(19);
  localparam logic [FCNT_W-1:0] FC_HDR_LEN   = FCNT_W'(20);
  localparam logic [FCNT_W-1:0] FC_SIZE_LEN  = FCNT_W'(4);

  localparam logic [7:0] MAGIC [0:3] = '{8'd75, 8'd80, 8'd80, 8'd32};

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SIZE,
    PH_NAMELEN,
    PH_NAME,
    PH_CONTENT
  } phase_t;

  typedef enum logic [2:0] {
    CLS_HEADER,
    CLS_SIZE,
    CLS_NAMELEN,
    CLS_NAME,
    CLS_CONTENT,
    CLS_IGNORED,
    CLS_END
  } cls_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_OPEN,
    ACT_DELETE
  } act_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_MAGIC,
    ERR_VERSION
  } err_t;

  typedef enum logic [2:0] {
    ST_BUSY,
    ST_BAD_MAGIC,
    ST_BAD_VERSION,
    ST_COMPLETE,
    ST_INCOMPLETE
  } status_t;

  // one result word
  typedef struct packed {
    cls_t               byte_class;
    logic [7:0]         byte_out;
    act_t               entry_action;
    logic               file_done;
    logic [FCNT_W-1:0]  content_offset;
    logic [31:0]        files_written;
    status_t            status;
  } res_t;

  // sticky error shown as status
  function automatic status_t err_to_status(err_t e);
    status_t s;
    unique case (e)
      ERR_MAGIC:   s = ST_BAD_MAGIC;
      ERR_VERSION: s = ST_BAD_VERSION;
      default:     s = ST_BUSY;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/uasp_core.sv
// ----------------------------------------------------------------------------
// uasp_core
// parser state and per-word classification, one word per step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uasp_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               req_type,
  input  logic [7:0]         data_byte,
  input  logic [31:0]        expected_version,
  output uasp_pkg::res_t     res
);

  uasp_pkg::phase_t                 phase_r, phase_nxt;
  logic [uasp_pkg::FCNT_W-1:0]      fcnt_r, fcnt_nxt;
  logic [31:0]                      shift_r, shift_nxt;
  logic [31:0]                      hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]                      done_r, done_nxt;
  logic [31:0]                      size_r, size_nxt;
  logic [7:0]                       name_r, name_nxt;
  uasp_pkg::err_t                   err_r, err_nxt;

  logic [uasp_pkg::FCNT_W-1:0]      fcnt_inc;
  logic [31:0]                      shift_in;
  logic [7:0]                       name_dec;
  logic                             end_now;

  assign fcnt_inc = fcnt_r + uasp_pkg::FCNT_W'(1);
  assign shift_in = {data_byte, shift_r[31:8]};
  assign name_dec = name_r - 8'd1;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= uasp_pkg::PH_HEADER;
      fcnt_r    <= '0;
      shift_r   <= '0;
      hdr_cnt_r <= '0;
      done_r    <= '0;
      size_r    <= '0;
      name_r    <= '0;
      err_r     <= uasp_pkg::ERR_NONE;
    end else if (step) begin
      phase_r   <= phase_nxt;
      fcnt_r    <= fcnt_nxt;
      shift_r   <= shift_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      done_r    <= done_nxt;
      size_r    <= size_nxt;
      name_r    <= name_nxt;
      err_r     <= err_nxt;
    end
  end

  // next state and result for the presented word
  always_comb begin
    phase_nxt   = phase_r;
    fcnt_nxt    = fcnt_r;
    shift_nxt   = shift_r;
    hdr_cnt_nxt = hdr_cnt_r;
    done_nxt    = done_r;
    size_nxt    = size_r;
    name_nxt    = name_r;
    err_nxt     = err_r;
    end_now     = 1'b0;

    res.byte_class     = uasp_pkg::CLS_IGNORED;
    res.byte_out       = data_byte;
    res.entry_action   = uasp_pkg::ACT_NONE;
    res.file_done      = 1'b0;
    res.content_offset = '0;

    if (req_type) begin
      // end marker: report only, no state change
      res.byte_class = uasp_pkg::CLS_END;
    end else if (err_r == uasp_pkg::ERR_NONE) begin
      unique case (phase_r)
        uasp_pkg::PH_HEADER: begin
          res.byte_class = uasp_pkg::CLS_HEADER;
          shift_nxt      = shift_in;
          if (fcnt_r < uasp_pkg::FC_MAGIC_LEN) begin
            if (data_byte != uasp_pkg::MAGIC[fcnt_r[1:0]]) begin
              err_nxt = uasp_pkg::ERR_MAGIC;
            end
          end else if (fcnt_r == uasp_pkg::FC_VER_LAST) begin
            if (shift_in != expected_version) begin
              err_nxt = uasp_pkg::ERR_VERSION;
            end
          end else if (fcnt_r == uasp_pkg::FC_CNT_LAST) begin
            hdr_cnt_nxt = shift_in;
          end
          fcnt_nxt = fcnt_inc;
          if (fcnt_inc >= uasp_pkg::FC_HDR_LEN) begin
            fcnt_nxt  = '0;
            phase_nxt = uasp_pkg::PH_SIZE;
          end
        end
        uasp_pkg::PH_SIZE: begin
          res.byte_class = uasp_pkg::CLS_SIZE;
          shift_nxt      = shift_in;
          fcnt_nxt       = fcnt_inc;
          if (fcnt_inc >= uasp_pkg::FC_SIZE_LEN) begin
            size_nxt  = shift_in;
            fcnt_nxt  = '0;
            phase_nxt = uasp_pkg::PH_NAMELEN;
          end
        end
        uasp_pkg::PH_NAMELEN: begin
          res.byte_class = uasp_pkg::CLS_NAMELEN;
          name_nxt       = data_byte;
          if (data_byte == 8'd0) begin
            end_now = 1'b1;
          end else begin
            phase_nxt = uasp_pkg::PH_NAME;
          end
        end
        uasp_pkg::PH_NAME: begin
          res.byte_class = uasp_pkg::CLS_NAME;
          name_nxt       = name_dec;
          end_now        = (name_dec == 8'd0);
        end
        uasp_pkg::PH_CONTENT: begin
          res.byte_class     = uasp_pkg::CLS_CONTENT;
          res.content_offset = fcnt_r;
          fcnt_nxt           = fcnt_inc;
          if (32'(fcnt_inc) >= size_r) begin
            res.file_done = 1'b1;
            done_nxt      = done_r + 32'd1;
            fcnt_nxt      = '0;
            phase_nxt     = uasp_pkg::PH_SIZE;
          end
        end
        default: begin
          phase_nxt = uasp_pkg::PH_HEADER;
        end
      endcase

      // entry name fully seen: open or delete
      if (end_now) begin
        if (size_r[31]) begin
          res.entry_action = uasp_pkg::ACT_DELETE;
          phase_nxt        = uasp_pkg::PH_SIZE;
        end else begin
          res.entry_action = uasp_pkg::ACT_OPEN;
          fcnt_nxt         = '0;
          if (size_r == 32'd0) begin
            res.file_done = 1'b1;
            done_nxt      = done_r + 32'd1;
            phase_nxt     = uasp_pkg::PH_SIZE;
          end else begin
            phase_nxt = uasp_pkg::PH_CONTENT;
          end
        end
      end
    end

    res.files_written = done_nxt;
    if (req_type && err_r == uasp_pkg::ERR_NONE) begin
      res.status = (done_r == hdr_cnt_r) ? uasp_pkg::ST_COMPLETE : uasp_pkg::ST_INCOMPLETE;
    end else begin
      res.status = uasp_pkg::err_to_status(err_nxt);
    end
  end

endmodule

FILE: rtl/update_archive_stream_parser.sv
// ----------------------------------------------------------------------------
// update_archive_stream_parser
// classifies an archive stream one word per cycle while the output is not stalled
// output: a word's result is registered and appears on out_* in the cycle after it is accepted
// throughput: one word per cycle; in_ready drops only while a result is held and out_ready is low
// reset: synchronous active-low rst_n clears parser state and the result slot's valid flag,
//   and sets the expected version to 10001
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module update_archive_stream_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         in_req_type,
  input  logic [7:0]   in_data_byte,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [2:0]   out_byte_class,
  output logic [7:0]   out_byte_out,
  output logic [1:0]   out_entry_action,
  output logic         out_file_done,
  output logic [30:0]  out_content_offset,
  output logic [31:0]  out_files_written,
  output logic [2:0]   out_status
);

  logic [31:0]        version_r;
  logic               out_valid_r;
  uasp_pkg::res_t     res_r;
  uasp_pkg::res_t     res;
  logic               accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;

  // version register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= uasp_pkg::VERSION_RST;
    end else if (cfg_valid) begin
      version_r <= cfg_wdata;
    end
  end

  uasp_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (accept),
    .req_type         (in_req_type),
    .data_byte        (in_data_byte),
    .expected_version (version_r),
    .res              (res)
  );

  // result slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte_class     = res_r.byte_class;
  assign out_byte_out       = res_r.byte_out;
  assign out_entry_action   = res_r.entry_action;
  assign out_file_done      = res_r.file_done;
  assign out_content_offset = res_r.content_offset;
  assign out_files_written  = res_r.files_written;
  assign out_status         = res_r.status;

endmodule

FILE: rtl/uasp_checker.sv
// ----------------------------------------------------------------------------
// uasp_checker
// port-level checks of the archive stream parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uasp_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_valid,
  input  logic         in_ready,
  input  logic         in_req_type,
  input  logic [7:0]   in_data_byte,
  input  logic         out_valid,
  input  logic         out_ready,
  input  logic [2:0]   out_byte_class,
  input  logic [7:0]   out_byte_out,
  input  logic [1:0]   out_entry_action,
  input  logic         out_file_done,
  input  logic [30:0]  out_content_offset,
  input  logic [31:0]  out_files_written,
  input  logic [2:0]   out_status
);

  // stalled word holds
  `UASP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte_out), "result dropped under stall")

  // open/delete only where a name ends
  `UASP_ASSERT_IMPL(a_action_cls, out_valid && out_entry_action != 2'd0, out_byte_class == uasp_pkg::CLS_NAMELEN || out_byte_class == uasp_pkg::CLS_NAME, "entry action outside name")

  // a file completes on a name end or a content word
  `UASP_ASSERT_IMPL(a_done_cls, out_valid && out_file_done, out_byte_class == uasp_pkg::CLS_NAMELEN || out_byte_class == uasp_pkg::CLS_NAME || out_byte_class == uasp_pkg::CLS_CONTENT, "file done on wrong class")

  // offset is zero outside content
  `UASP_ASSERT_IMPL(a_offset_zero, out_valid && out_byte_class != uasp_pkg::CLS_CONTENT, out_content_offset == 31'd0, "offset outside content")

  // final status only on the end marker
  `UASP_ASSERT_IMPL(a_final_status, out_valid && (out_status == uasp_pkg::ST_COMPLETE || out_status == uasp_pkg::ST_INCOMPLETE), out_byte_class == uasp_pkg::CLS_END, "final status before end")

endmodule

bind update_archive_stream_parser uasp_checker u_uasp_checker (.*);
